### hw/rtl/svt_pkg.sv
// shared types and operation codes for the sorted value table
`default_nettype none

package svt_pkg;

    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 6;

    // operation codes carried in the func field
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    // commit strobes broadcast to every cell
    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } t_cell_ctrl;

    // what one cell hands to its right-hand neighbor
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      le;
        logic                      lt;
    } t_cell_link;

endpackage

`default_nettype wire

### hw/rtl/svt_cell.sv
// one storage cell of the sorted chain: compare against the key and shift
`default_nettype none

module svt_cell
    import svt_pkg::*;
#(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 6
) (
    input  wire logic                      i_clk,
    input  wire t_cell_ctrl                i_ctrl,
    input  wire logic [CNT_W-1:0]          i_count,
    input  wire logic signed [VALUE_W-1:0] i_key,
    input  wire t_cell_link                i_left,
    input  wire logic signed [VALUE_W-1:0] i_right_value,
    output t_cell_link                     o_link,
    output logic                           o_hit
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      w_occ;
    logic                      w_le;
    logic                      w_lt;

    assign w_occ = CNT_W'(IDX) < i_count;
    assign w_le  = w_occ && (r_value <= i_key);
    assign w_lt  = w_occ && (r_value <  i_key);

    // first copy of the key sits where the less-than run ends
    assign o_hit = w_occ && (r_value == i_key) && i_left.lt;

    assign o_link.value = r_value;
    assign o_link.le    = w_le;
    assign o_link.lt    = w_lt;

    always_comb begin
        priority if (i_ctrl.ins_en && !w_le) begin
            // new key lands at the boundary, everything past it moves right
            n_value = i_left.le ? i_key : i_left.value;
        end else if (i_ctrl.rem_en && !w_lt) begin
            n_value = i_right_value;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

### hw/rtl/sorted_value_table_core.sv
// top level of the sorted value table: control, cell chain and result register
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_ready | i_func, i_value
//  out     | output    | o_out_valid/i_out_ready | o_ok, o_head_value, o_tail_value,
//          |           |                         | o_count, o_full_res
//
// every beat passes through the states accept, evaluate (find the first matching cell),
// commit (all cells shift at once), report (result into the output register)
// the report cycle waits while a previous result has not been taken
// reset clears the entry count and the control state; cell contents need none
// a clear only zeroes the count, cells at or past the count are never looked at
`default_nettype none

module sorted_value_table_core
    import svt_pkg::*;
#(
    parameter int unsigned CAPACITY = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [FUNC_W-1:0]         i_func,
    input  wire logic signed [VALUE_W-1:0] i_value,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic                           o_ok,
    output logic signed [VALUE_W-1:0]      o_head_value,
    output logic signed [VALUE_W-1:0]      o_tail_value,
    output logic [COUNT_W-1:0]             o_count,
    output logic                           o_full_res
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_W = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_COMMIT,
        S_REPORT
    } t_state;

    t_state                    r_state;
    logic [FUNC_W-1:0]         r_func;
    logic signed [VALUE_W-1:0] r_value;
    logic [CNT_W-1:0]          r_count;
    logic                      r_found;
    logic                      r_ok;

    logic                      r_out_valid;
    logic                      r_out_ok;
    logic signed [VALUE_W-1:0] r_out_head;
    logic signed [VALUE_W-1:0] r_out_tail;
    logic [COUNT_W-1:0]        r_out_count;
    logic                      r_out_full;

    t_cell_ctrl                w_ctrl;
    t_cell_link                w_link [CAPACITY];
    t_cell_link                w_edge;
    logic [CAPACITY-1:0]       w_hit;
    logic                      w_has_room;
    logic [CNT_W-1:0]          w_last;
    logic signed [VALUE_W-1:0] w_tail;
    logic [CNT_W+COUNT_W-1:0]  w_cnt_ext;
    logic                      w_in_beat;
    logic                      w_out_free;

    assign w_in_beat  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_has_room = r_count < CNT_W'(CAPACITY);

    // commit strobes only live during the commit cycle
    assign w_ctrl.ins_en = (r_state == S_COMMIT) && (r_func == FUNC_INSERT) && w_has_room;
    assign w_ctrl.rem_en = (r_state == S_COMMIT) && (r_func == FUNC_REMOVE) && r_found;

    // left edge of the chain looks like an endless run of smaller values
    assign w_edge.value = r_value;
    assign w_edge.le    = 1'b1;
    assign w_edge.lt    = 1'b1;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        svt_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_count       (r_count),
            .i_key         (r_value),
            .i_left        ((g == 0) ? w_edge : w_link[(g == 0) ? 0 : g - 1]),
            .i_right_value (w_link[(g == CAPACITY - 1) ? g : g + 1].value),
            .o_link        (w_link[g]),
            .o_hit         (w_hit[g])
        );
    end

    // largest entry sits in the last occupied cell
    assign w_last    = r_count - 1'b1;
    assign w_tail    = w_link[w_last[IDX_W-1:0]].value;
    assign w_cnt_ext = (CNT_W + COUNT_W)'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // the report cycle reloads the output register itself
            if (r_out_valid && i_out_ready && r_state != S_REPORT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_beat) begin
                        r_func  <= i_func;
                        r_value <= i_value;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_found <= |w_hit;
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    unique case (r_func)
                        FUNC_INSERT: begin
                            if (w_has_room) begin
                                r_count <= r_count + 1'b1;
                                r_ok    <= 1'b1;
                            end else begin
                                r_ok    <= 1'b0;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (r_found) begin
                                r_count <= r_count - 1'b1;
                                r_ok    <= 1'b1;
                            end else begin
                                r_ok    <= 1'b0;
                            end
                        end
                        FUNC_CLEAR: begin
                            r_count <= '0;
                            r_ok    <= 1'b1;
                        end
                        default: begin
                            r_ok <= 1'b0;
                        end
                    endcase
                    r_state <= S_REPORT;
                end
                S_REPORT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_ok    <= r_ok;
                        r_out_head  <= (r_count == '0) ? '0 : w_link[0].value;
                        r_out_tail  <= (r_count == '0) ? '0 : w_tail;
                        r_out_count <= w_cnt_ext[COUNT_W-1:0];
                        r_out_full  <= r_count == CNT_W'(CAPACITY);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready   = r_state == S_IDLE;
    assign o_out_valid  = r_out_valid;
    assign o_ok         = r_out_ok;
    assign o_head_value = r_out_head;
    assign o_tail_value = r_out_tail;
    assign o_count      = r_out_count;
    assign o_full_res   = r_out_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && r_func != FUNC_CLEAR) |=>
        (r_count == $past(r_count) || r_count == $past(r_count) + 1'b1 ||
         r_count == $past(r_count) - 1'b1))
        else $error("count moved by more than one entry");

    a_remove_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && r_func == FUNC_REMOVE && r_found) |=>
        (r_ok && r_count == $past(r_count) - 1'b1))
        else $error("successful removal did not drop one entry");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_count == '0 && !r_out_full) |->
        (r_out_head == '0 && r_out_tail == '0))
        else $error("empty table reported nonzero head or tail");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && $rose(r_out_valid) && r_out_count != '0) |->
        (r_out_head <= r_out_tail))
        else $error("head above tail");

endmodule

`default_nettype wire
